### src/bda_pkg.sv
package bda_pkg;

  // field widths fixed by the item formats
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned IN_TIME_W  = 32;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned DEB_W      = 20;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned SLOTS      = 4;

  // threshold (limit + 1) * 1000 fits in 27 bits for a 16-bit limit
  localparam int unsigned THR_W      = 27;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET_US = 20'd10000;
  localparam logic [9:0]       US_PER_MS         = 10'd1000;

  // per-button phase codes, the unused code behaves as initial
  localparam logic [1:0] PH_INITIAL  = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_STABLE   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_RELEASED = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE = 3'd2;
  localparam logic [2:0] REG_LIMIT_B0 = 3'd3;
  localparam logic [2:0] REG_LIMIT_B1 = 3'd4;
  localparam logic [2:0] REG_LIMIT_B2 = 3'd5;
  localparam logic [2:0] REG_LIMIT_B3 = 3'd6;

  typedef struct packed {
    logic [IDX_W-1:0] button;
    logic             pressed;
    logic             last;
  } evt_t;

endpackage

### src/bda_poll_if.sv
interface bda_poll_if;
  logic                              valid;
  logic                              ready;
  logic [bda_pkg::IDX_W-1:0]         button_index;
  logic                              pin_level;
  logic [bda_pkg::IN_TIME_W-1:0]     time_us;

  modport source (output valid, output button_index, output pin_level, output time_us,
                  input ready);
  modport sink (input valid, input button_index, input pin_level, input time_us,
                output ready);
endinterface

### src/bda_event_if.sv
interface bda_event_if;
  logic                        valid;
  logic                        ready;
  logic [bda_pkg::IDX_W-1:0]   event_button;
  logic                        is_pressed;
  logic                        last_of_run;

  modport source (output valid, output event_button, output is_pressed, output last_of_run,
                  input ready);
  modport sink (input valid, input event_button, input is_pressed, input last_of_run,
                output ready);
endinterface

### src/button_debounce_autorepeat_top.sv
// Debouncer with auto-repeat for up to four buttons. Each poll word carries a
// button index, the sampled pin level and a free-running microsecond time; a
// poll of a button that is not enabled (or whose index is not below
// BUTTON_COUNT) is dropped. The block takes one poll per clock while the queue
// has room: a poll is held in an input register, evaluated against that
// button's state, and its zero, one or two event words are pushed into a
// four-word output queue that feeds the event port. A poll is moved on
// only while the queue holds two words or fewer; with the event side always
// ready, polls that make at most one event never stall, and a poll that
// makes two events puts two words into the queue, which is what limits the
// sustained rate when such polls come in a row. The debounce
// time is in microseconds, the repeat interval in milliseconds: a repeat press
// is sent when the whole milliseconds since the last repeat exceed the
// interval. Writing a 1 into an enable bit that was 0 puts that button back
// into its initial phase, where the next poll only latches the level.
// Registers sit at byte address 4*i: enable mask, released levels, debounce
// time, then the four repeat limits.
module button_debounce_autorepeat_top #(
  parameter int BUTTON_COUNT = 4,
  parameter int TIME_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  bda_poll_if.sink    poll,
  bda_event_if.source evt,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // compare width big enough for both elapsed time and repeat threshold
  localparam int CMP_W = (TIME_BITS > bda_pkg::THR_W) ? TIME_BITS : bda_pkg::THR_W;

  // ---------------------------------------------------------------- registers
  logic [bda_pkg::MASK_W-1:0]  enable_mask;
  logic [bda_pkg::MASK_W-1:0]  released_levels;
  logic [bda_pkg::DEB_W-1:0]   debounce_time_us;
  logic [bda_pkg::LIMIT_W-1:0] repeat_limit [bda_pkg::SLOTS];

  logic [2:0] reg_idx;
  logic       cfg_wr;
  logic [bda_pkg::MASK_W-1:0] enable_rising;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign enable_rising = pwdata[bda_pkg::MASK_W-1:0] & ~enable_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask      <= '0;
      released_levels  <= '0;
      debounce_time_us <= bda_pkg::DEBOUNCE_RESET_US;
      for (int i = 0; i < bda_pkg::SLOTS; i++) begin
        repeat_limit[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bda_pkg::REG_ENABLE:   enable_mask      <= pwdata[bda_pkg::MASK_W-1:0];
        bda_pkg::REG_RELEASED: released_levels  <= pwdata[bda_pkg::MASK_W-1:0];
        bda_pkg::REG_DEBOUNCE: debounce_time_us <= pwdata[bda_pkg::DEB_W-1:0];
        bda_pkg::REG_LIMIT_B0: repeat_limit[0]  <= pwdata[bda_pkg::LIMIT_W-1:0];
        bda_pkg::REG_LIMIT_B1: repeat_limit[1]  <= pwdata[bda_pkg::LIMIT_W-1:0];
        bda_pkg::REG_LIMIT_B2: repeat_limit[2]  <= pwdata[bda_pkg::LIMIT_W-1:0];
        bda_pkg::REG_LIMIT_B3: repeat_limit[3]  <= pwdata[bda_pkg::LIMIT_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bda_pkg::REG_ENABLE:   prdata = 32'(enable_mask);
      bda_pkg::REG_RELEASED: prdata = 32'(released_levels);
      bda_pkg::REG_DEBOUNCE: prdata = 32'(debounce_time_us);
      bda_pkg::REG_LIMIT_B0: prdata = 32'(repeat_limit[0]);
      bda_pkg::REG_LIMIT_B1: prdata = 32'(repeat_limit[1]);
      bda_pkg::REG_LIMIT_B2: prdata = 32'(repeat_limit[2]);
      bda_pkg::REG_LIMIT_B3: prdata = 32'(repeat_limit[3]);
      default:               prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ poll register
  logic                        s1_valid;
  logic [bda_pkg::IDX_W-1:0]   s1_button;
  logic                        s1_level;
  logic [TIME_BITS-1:0]        s1_time;
  logic                        advance;
  logic                        poll_take;

  // output queue
  localparam int QD = 4;
  bda_pkg::evt_t queue [QD];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [1:0] npush;
  logic       pop;

  // the poll in stage one is evaluated once the queue has room for two words
  assign advance   = s1_valid && (count <= 3'd2);
  assign poll.ready = !s1_valid || advance;
  assign poll_take = poll.valid && poll.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= poll_take || (s1_valid && !advance);
    end
  end

  // time is cut to TIME_BITS on the way in, so all differences wrap there
  always_ff @(posedge clk) begin
    if (poll_take) begin
      s1_button <= poll.button_index;
      s1_level  <= poll.pin_level;
      s1_time   <= TIME_BITS'(poll.time_us);
    end
  end

  // ------------------------------------------------------ per-button state
  logic [1:0]           phase          [bda_pkg::SLOTS];
  logic                 stable_level   [bda_pkg::SLOTS];
  logic [TIME_BITS-1:0] debounce_start [bda_pkg::SLOTS];
  logic [TIME_BITS-1:0] repeat_start   [bda_pkg::SLOTS];
  logic                 repeat_armed   [bda_pkg::SLOTS];

  logic                 upd;
  logic                 rel;
  logic [1:0]           cur_phase;
  logic                 cur_stable;
  logic                 cur_armed;
  logic [TIME_BITS-1:0] deb_elapsed;
  logic [TIME_BITS-1:0] rep_elapsed;
  logic [bda_pkg::LIMIT_W:0] limit_p1;
  logic [CMP_W-1:0]     rep_thr;
  logic                 deb_done;
  logic                 rep_due;

  logic [1:0]           phase_next;
  logic                 stable_next;
  logic                 armed_next;
  logic                 deb_start_load;
  logic                 rep_start_load;
  bda_pkg::evt_t        ev0;
  bda_pkg::evt_t        ev1;

  assign upd = advance && (32'(s1_button) < BUTTON_COUNT) && enable_mask[s1_button];
  assign rel = released_levels[s1_button];

  assign cur_phase   = phase[s1_button];
  assign cur_stable  = stable_level[s1_button];
  assign cur_armed   = repeat_armed[s1_button];
  assign deb_elapsed = s1_time - debounce_start[s1_button];
  assign rep_elapsed = s1_time - repeat_start[s1_button];

  // whole ms elapsed > limit  <=>  elapsed us >= (limit + 1) * 1000
  assign limit_p1 = {1'b0, repeat_limit[s1_button]} + 1'b1;
  assign rep_thr  = CMP_W'(limit_p1) * CMP_W'(bda_pkg::US_PER_MS);
  assign rep_due  = CMP_W'(rep_elapsed) >= rep_thr;
  assign deb_done = deb_elapsed >= TIME_BITS'(debounce_time_us);

  always_comb begin
    phase_next     = cur_phase;
    stable_next    = cur_stable;
    armed_next     = cur_armed;
    deb_start_load = 1'b0;
    rep_start_load = 1'b0;
    npush          = 2'd0;
    ev0            = '{button: s1_button, pressed: 1'b0, last: 1'b1};
    ev1            = '{button: s1_button, pressed: 1'b0, last: 1'b1};
    unique case (cur_phase)
      bda_pkg::PH_STABLE: begin
        if (cur_stable != s1_level) begin
          // level moved: start timing the debounce
          phase_next     = bda_pkg::PH_DEBOUNCE;
          deb_start_load = 1'b1;
          armed_next     = 1'b0;
        end else if (s1_level != rel) begin
          if (!cur_armed) begin
            armed_next     = 1'b1;
            rep_start_load = 1'b1;
          end else if (rep_due) begin
            rep_start_load = 1'b1;
            ev0.pressed    = 1'b1;
            npush          = 2'd1;
          end
        end else begin
          armed_next = 1'b0;
        end
      end
      bda_pkg::PH_DEBOUNCE: begin
        if (deb_done) begin
          if (cur_stable == s1_level) begin
            // level bounced back: report the missed change, then the level
            ev0.pressed = ~cur_stable ^ rel;
            ev0.last    = 1'b0;
            ev1.pressed = s1_level ^ rel;
            npush       = 2'd2;
          end else begin
            ev0.pressed = s1_level ^ rel;
            npush       = 2'd1;
          end
          stable_next = s1_level;
          phase_next  = bda_pkg::PH_STABLE;
        end
      end
      default: begin
        // initial phase and the unused code
        stable_next = s1_level;
        phase_next  = bda_pkg::PH_STABLE;
        armed_next  = 1'b0;
      end
    endcase
    if (!upd) begin
      npush = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bda_pkg::SLOTS; i++) begin
        phase[i]          <= bda_pkg::PH_INITIAL;
        stable_level[i]   <= 1'b0;
        debounce_start[i] <= '0;
        repeat_start[i]   <= '0;
        repeat_armed[i]   <= 1'b0;
      end
    end else begin
      for (int i = 0; i < bda_pkg::SLOTS; i++) begin
        if (cfg_wr && (reg_idx == bda_pkg::REG_ENABLE) && enable_rising[i]) begin
          phase[i] <= bda_pkg::PH_INITIAL;
        end else if (upd && (s1_button == i[bda_pkg::IDX_W-1:0])) begin
          phase[i]        <= phase_next;
          stable_level[i] <= stable_next;
          repeat_armed[i] <= armed_next;
          if (deb_start_load) begin
            debounce_start[i] <= s1_time;
          end
          if (rep_start_load) begin
            repeat_start[i] <= s1_time;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------ output queue
  assign pop = evt.valid && evt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + npush;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(npush) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      queue[wr_ptr] <= ev0;
    end
    if (npush == 2'd2) begin
      queue[wr_ptr + 2'd1] <= ev1;
    end
  end

  assign evt.valid        = (count != 3'd0);
  assign evt.event_button = queue[rd_ptr].button;
  assign evt.is_pressed   = queue[rd_ptr].pressed;
  assign evt.last_of_run  = queue[rd_ptr].last;

  // ---------------------------------------------------------------- checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'(QD))
    else $error("output queue overfilled");

  a_queue_count: assert property (@(posedge clk) disable iff (rst)
      1'b1 |=> count == $past(count) + 3'($past(npush)) - 3'($past(pop)))
    else $error("queue count out of step with pushes and pops");

  a_run_follows: assert property (@(posedge clk) disable iff (rst)
      (evt.valid && !evt.last_of_run) |-> count >= 3'd2)
    else $error("first word of a pair without its partner queued");

  a_poll_held: assert property (@(posedge clk) disable iff (rst)
      poll_take |=> s1_valid)
    else $error("accepted poll lost before evaluation");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
      (npush != 2'd0) |-> (advance && count <= 3'd2))
    else $error("events pushed without room in the queue");

endmodule
